FILE: design/akt_pkg.sv
// ----------------------------------------------------------------------------
// akt_pkg
// Shared types and constants of the access key table loader and lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package akt_pkg;

    localparam int KEY_CAPACITY = 128;
    localparam int KEY_W        = 32;
    localparam int ADDR_W       = (KEY_CAPACITY > 1) ? $clog2(KEY_CAPACITY) : 1;
    localparam int CNT_W        = $clog2(KEY_CAPACITY + 1);
    localparam int COUNT_OUT_W  = 8;

    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    typedef enum logic [1:0] {
        FUNC_BEGIN = 2'd0,
        FUNC_CHAR  = 2'd1,
        FUNC_END   = 2'd2,
        FUNC_QUERY = 2'd3
    } t_func;

    typedef struct packed {
        logic                   granted;
        logic [COUNT_OUT_W-1:0] key_count;
    } t_result;

endpackage

`default_nettype wire

FILE: design/access_key_table_loader_lookup_core.sv
// ----------------------------------------------------------------------------
// access_key_table_loader_lookup_core
// Badge key whitelist: loads keys from an ASCII decimal list, answers lookups.
//
// Input channel (i_in_valid / o_in_stall) carries one request: begin load,
// list character, end load or query. Every request yields one result on the
// output channel (o_out_valid / i_out_stall): granted flag and the committed
// key count. Requests are handled one at a time.
// Handling from accept to result loaded in the output register:
//   begin load, end load, comma, ignored char : straight to the result state
//   digit (read-modify-write of one key)      : key read, then written back
//   query : N = keys compared (0..committed count), at most
//           KEY_CAPACITY = 128, read through the single read port of the key
//           RAM, one stored key per cycle.
// The next request is accepted in the cycle after the result enters the output
// register. A stalled receiver holds the result there, and once a second
// result is ready the block stalls its input until the first one leaves.
// Reset clears the entry valid bits, load position and count, so the table
// reads as all zero keys; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module access_key_table_loader_lookup_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_func,
    input  wire logic [7:0]  i_list_char,
    input  wire logic [31:0] i_query_tag,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_granted,
    output logic [akt_pkg::COUNT_OUT_W-1:0] o_key_count
);

    import akt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DIGIT = 4'b0010,
        S_SCAN  = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_pos, n_pos;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [KEY_CAPACITY-1:0] r_valid, n_valid;
    logic [ADDR_W-1:0]   r_idx, n_idx;
    logic                r_granted, n_granted;
    logic [7:0]          r_char, n_char;
    logic [KEY_W-1:0]    r_tag, n_tag;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [KEY_W-1:0]    ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [KEY_W-1:0]    ram_rdata;

    logic                in_acc;
    logic                res_ready;
    logic                res_load;
    t_result             res_in;
    t_result             res_out;

    logic [ADDR_W-1:0]   pos_addr;
    logic [ADDR_W-1:0]   idx_inc;
    logic [KEY_W-1:0]    cur_key;
    logic [KEY_W-1:0]    digit_val;
    logic [KEY_W-1:0]    acc_key;
    logic [KEY_W-1:0]    new_key;

    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    assign pos_addr = r_pos[ADDR_W-1:0];
    assign idx_inc  = r_idx + ADDR_W'(1);

    // never-written entries read as zero
    assign cur_key   = r_valid[r_idx] ? ram_rdata : '0;
    assign acc_key   = r_valid[pos_addr] ? ram_rdata : '0;
    assign digit_val = KEY_W'(r_char[3:0]);
    // key * 10 + digit, wrapping
    assign new_key   = {acc_key[KEY_W-4:0], 3'b000} + {acc_key[KEY_W-2:0], 1'b0} + digit_val;

    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_count   = r_count;
        n_valid   = r_valid;
        n_idx     = r_idx;
        n_granted = r_granted;
        n_char    = r_char;
        n_tag     = r_tag;
        ram_we    = 1'b0;
        ram_waddr = pos_addr;
        ram_wdata = new_key;
        ram_raddr = '0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_granted = 1'b0;
                    n_state   = S_DONE;
                    case (t_func'(i_func))
                        FUNC_BEGIN: begin
                            n_valid = '0;
                            n_pos   = '0;
                            n_count = '0;
                        end
                        FUNC_CHAR: begin
                            if (r_pos < CNT_W'(KEY_CAPACITY)) begin
                                if (i_list_char == CHAR_COMMA) begin
                                    n_pos = r_pos + CNT_W'(1);
                                end else if (i_list_char inside {[CHAR_ZERO:CHAR_NINE]}) begin
                                    ram_raddr = pos_addr;
                                    n_char    = i_list_char;
                                    n_state   = S_DIGIT;
                                end
                            end
                        end
                        FUNC_END: begin
                            n_count = r_pos;
                        end
                        FUNC_QUERY: begin
                            n_tag     = i_query_tag;
                            n_idx     = '0;
                            ram_raddr = '0;
                            if (r_count != '0) begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_DIGIT: begin
                ram_we            = 1'b1;
                n_valid[pos_addr] = 1'b1;
                n_state           = S_DONE;
            end
            S_SCAN: begin
                if (cur_key == r_tag) begin
                    n_granted = 1'b1;
                    n_state   = S_DONE;
                end else if ((CNT_W'(r_idx) + CNT_W'(1)) == r_count) begin
                    n_state = S_DONE;
                end else begin
                    n_idx     = idx_inc;
                    ram_raddr = idx_inc;
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pos     <= '0;
            r_count   <= '0;
            r_valid   <= '0;
            r_granted <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_count   <= n_count;
            r_valid   <= n_valid;
            r_granted <= n_granted;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_char <= n_char;
        r_tag  <= n_tag;
    end

    akt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (KEY_CAPACITY)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign res_load          = (r_state == S_DONE) && res_ready;
    assign res_in.granted    = r_granted;
    assign res_in.key_count  = COUNT_OUT_W'(r_count);

    akt_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_load),
        .i_res   (res_in),
        .o_ready (res_ready),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (res_out)
    );

    assign o_granted   = res_out.granted;
    assign o_key_count = res_out.key_count;

endmodule

`default_nettype wire

FILE: design/akt_ram.sv
// ----------------------------------------------------------------------------
// akt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module akt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: design/akt_out_reg.sv
// ----------------------------------------------------------------------------
// akt_out_reg
// Result holding register with valid/stall handshake toward the receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module akt_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire akt_pkg::t_result i_res,
    output logic                  o_ready,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output akt_pkg::t_result      o_res
);

    import akt_pkg::*;

    logic    r_valid;
    t_result r_res;

    // a new result may load when empty or when the held one leaves this cycle
    assign o_ready = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the badge key whitelist loader and lookup.
// A short table of directed requests is followed by random load sequences
// (begin, decimal keys split by commas, end), lookups and noise. Each accepted
// request is run through a local model of the key table, and every result is
// compared with the oldest pending expectation. Both channels idle at random.
// ----------------------------------------------------------------------------

module tb;
    import akt_pkg::*;

    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 8;
    localparam int ITEMS_TARGET    = 1050;
    localparam int LONG_HOLD       = 300;
    localparam int WATCHDOG_CYCLES = 4000;
    localparam int TAIL_CYCLES     = 200;
    localparam int MAX_REPORTS     = 10;
    localparam int DIR_ROWS        = 25;
    localparam logic [31:0] DEC_BASE = 32'd10;

    typedef struct packed {
        t_func       func;
        logic [7:0]  ch;
        logic [31:0] tag;
        logic        typed;
        t_result     res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [1:0]  i_func = FUNC_BEGIN;
    logic [7:0]  i_list_char = '0;
    logic [31:0] i_query_tag = '0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_granted;
    logic [COUNT_OUT_W-1:0] o_key_count;

    // typed expectation travels with the request payload
    logic        req_typed = 1'b0;
    t_result     req_res = '0;

    // model state
    logic [31:0] key_mem [KEY_CAPACITY];
    logic [7:0]  load_pos;
    logic [7:0]  commit_cnt;

    t_result     grant_q [$];
    logic [31:0] loaded_keys [$];
    t_row        dir_table [DIR_ROWS];

    bit          long_hold_req = 1'b0;
    int          burst_left = 0;
    int          sent_cnt = 0;
    int          query_cnt = 0;
    int          full_loads = 0;
    int          checked_cnt = 0;
    int          granted_cnt = 0;
    int          mismatches = 0;

    wire in_fire  = i_in_valid && !o_in_stall;
    wire out_fire = o_out_valid && !i_out_stall;

    access_key_table_loader_lookup_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_func      (i_func),
        .i_list_char (i_list_char),
        .i_query_tag (i_query_tag),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_granted   (o_granted),
        .o_key_count (o_key_count)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic t_result predict_access(t_func f, logic [7:0] ch, logic [31:0] tag);
        t_result r;
        r.granted = 1'b0;
        case (f)
            FUNC_BEGIN: begin
                foreach (key_mem[i]) key_mem[i] = '0;
                load_pos   = '0;
                commit_cnt = '0;
            end
            FUNC_CHAR: begin
                // full table swallows digits and commas alike
                if (load_pos < KEY_CAPACITY) begin
                    if (ch == CHAR_COMMA)
                        load_pos = load_pos + 8'd1;
                    else if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
                        key_mem[load_pos] = key_mem[load_pos] * DEC_BASE
                                            + 32'(ch - CHAR_ZERO);
                end
            end
            FUNC_END: commit_cnt = load_pos;
            default: begin
                for (int i = 0; i < commit_cnt; i++)
                    if (key_mem[i] == tag) r.granted = 1'b1;
            end
        endcase
        r.key_count = commit_cnt;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // scoreboard
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : scoreboard
        t_result want;
        t_result model_res;
        if (i_rst_n) begin
            if (out_fire) begin
                if (grant_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result with no request pending: granted=%0b count=%0d",
                                 $time, o_granted, o_key_count);
                end else begin
                    want = grant_q.pop_front();
                    checked_cnt++;
                    if (o_granted) granted_cnt++;
                    if (o_granted !== want.granted || o_key_count !== want.key_count) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: mismatch granted exp=%0b got=%0b, count exp=%0d got=%0d",
                                     $time, want.granted, o_granted, want.key_count,
                                     o_key_count);
                    end
                end
            end
            if (in_fire) begin
                model_res = predict_access(t_func'(i_func), i_list_char, i_query_tag);
                grant_q.push_back(req_typed ? req_res : model_res);
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver stall pattern, with one long hold-off on request
    // ------------------------------------------------------------------------
    always begin : out_stall_gen
        int mode;
        int mode_left;
        int phase;
        mode = 0;
        mode_left = 0;
        phase = 0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                phase++;
                case (mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 9) < 3);
                    2: i_out_stall <= (phase % 3 == 0);
                    default: i_out_stall <= ((phase / 8) % 2 == 1);
                endcase
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_CYCLES) begin
            @(posedge i_clk);
            if (!i_rst_n || in_fire || out_fire)
                quiet = 0;
            else
                quiet++;
        end
        $display("[access_key_table_loader_lookup_core] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------------
    task automatic send_req(t_func f, logic [7:0] ch, logic [31:0] tag,
                            logic typed = 1'b0, t_result res = '0);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_func      <= f;
        i_list_char <= ch;
        i_query_tag <= tag;
        req_typed   <= typed;
        req_res     <= res;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent_cnt++;
        if (f == FUNC_QUERY) query_cnt++;
    endtask

    // hold the sender until every pending result has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (grant_q.size() != 0);
    endtask

    task automatic send_noise_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (c == CHAR_COMMA || (c >= CHAR_ZERO && c <= CHAR_NINE));
        send_req(FUNC_CHAR, c, $urandom);
    endtask

    task automatic run_queries(int n);
        logic [31:0] tag;
        int sel;
        for (int q = 0; q < n; q++) begin
            sel = $urandom_range(0, 9);
            if (sel < 6 && loaded_keys.size() != 0)
                tag = loaded_keys[$urandom_range(0, loaded_keys.size() - 1)];
            else if (sel == 6)
                tag = $urandom_range(0, 1) ? '1 : '0;
            else if (sel == 7 && loaded_keys.size() != 0)
                tag = loaded_keys[$urandom_range(0, loaded_keys.size() - 1)] + 32'd1;
            else
                tag = $urandom;
            send_req(FUNC_QUERY, 8'($urandom), tag);
        end
    endtask

    task automatic run_noise(int n);
        t_func f;
        logic [7:0] c;
        int sel;
        for (int j = 0; j < n; j++) begin
            sel = $urandom_range(0, 9);
            f = (sel == 0) ? FUNC_BEGIN : (sel < 3) ? FUNC_END :
                (sel < 7) ? FUNC_CHAR : FUNC_QUERY;
            c = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 4) < 2)
                c = $urandom_range(0, 1) ? CHAR_COMMA : CHAR_ZERO + 8'($urandom_range(0, 9));
            send_req(f, c, $urandom);
        end
    endtask

    // one whole list upload: begin, keys with commas, optional trailing
    // number, end, then a few lookups
    task automatic load_list(int n_keys, bit mostly_empty);
        logic [7:0]  digs [$];
        logic [31:0] src;
        logic [31:0] val;
        int kind;
        int k;
        bit trailing;
        send_req(FUNC_BEGIN, 8'($urandom), $urandom);
        loaded_keys.delete();
        if (n_keys >= KEY_CAPACITY) full_loads++;
        for (k = 0; k <= n_keys; k++) begin
            trailing = (k == n_keys);
            if (trailing && $urandom_range(0, 3) != 0) break;
            digs.delete();
            kind = mostly_empty ? (($urandom_range(0, 9) == 0) ? 1 : 0)
                                : $urandom_range(0, 4);
            case (kind)
                0: src = '0;
                1: src = $urandom_range(0, 999);
                2: src = $urandom;
                3: src = $urandom_range(0, 1) ? '1 : '0;
                default: src = '0;
            endcase
            if (kind == 4) begin
                // more digits than 32 bits hold, so the key wraps
                repeat ($urandom_range(11, 14)) digs.push_back(8'($urandom_range(0, 9)));
            end else if (kind != 0) begin
                do begin
                    digs.push_front(8'(src % DEC_BASE));
                    src = src / DEC_BASE;
                end while (src != 0);
            end
            val = '0;
            foreach (digs[i]) begin
                if ($urandom_range(0, 9) == 0) send_noise_char();
                send_req(FUNC_CHAR, CHAR_ZERO + digs[i], $urandom);
                val = val * DEC_BASE + 32'(digs[i]);
            end
            loaded_keys.push_back(val);
            if (!trailing) send_req(FUNC_CHAR, CHAR_COMMA, $urandom);
        end
        send_req(FUNC_END, 8'($urandom), $urandom);
        if ($urandom_range(0, 4) == 0) send_req(FUNC_END, 8'($urandom), $urandom);
        run_queries($urandom_range(3, 8));
    endtask

    initial begin : stimulus
        int iter;
        int pick;
        dir_table = '{
            '{FUNC_QUERY, 8'h00,      32'h0000_0000, 1'b1, '{1'b0, 8'd0}},
            '{FUNC_END,   8'h00,      32'h0000_0000, 1'b1, '{1'b0, 8'd0}},
            '{FUNC_BEGIN, 8'hFF,      32'hFFFF_FFFF, 1'b1, '{1'b0, 8'd0}},
            '{FUNC_CHAR,  CHAR_ZERO,  32'h0000_0000, 1'b0, '{1'b0, 8'd0}},
            '{FUNC_CHAR,  CHAR_COMMA, 32'h0000_0000, 1'b0, '{1'b0, 8'd0}},
            '{FUNC_CHAR,  CHAR_NINE,  32'h0000_0000, 1'b0, '{1'b0, 8'd0}},
            '{FUNC_CHAR,  8'h2F,      32'h0000_0000, 1'b0, '{1'b0, 8'd0}},
            '{FUNC_CHAR,  8'hFF,      32'hFFFF_FFFF, 1'b0, '{1'b0, 8'd0}},
            '{FUNC_CHAR,  8'h00,      32'h0000_0000, 1'b0, '{1'b0, 8'd0}},
            '{FUNC_CHAR,  8'h3A,      32'h0000_0000, 1'b0, '{1'b0, 8'd0}},
            '{FUNC_CHAR,  CHAR_NINE,  32'h0000_0000, 1'b0, '{1'b0, 8'd0}},
            '{FUNC_CHAR,  CHAR_COMMA, 32'h0000_0000, 1'b0, '{1'b0, 8'd0}},
            '{FUNC_CHAR,  8'h37,      32'h0000_0000, 1'b0, '{1'b0, 8'd0}},
            // trailing 7 has no comma yet: two keys committed
            '{FUNC_END,   8'h00,      32'h0000_0000, 1'b1, '{1'b0, 8'd2}},
            '{FUNC_QUERY, 8'hFF,      32'd0,         1'b1, '{1'b1, 8'd2}},
            '{FUNC_QUERY, 8'h00,      32'd99,        1'b1, '{1'b1, 8'd2}},
            '{FUNC_QUERY, 8'h00,      32'd7,         1'b1, '{1'b0, 8'd2}},
            '{FUNC_QUERY, 8'h00,      32'd997,       1'b0, '{1'b0, 8'd0}},
            // comma without begin load picks up the pending 7
            '{FUNC_CHAR,  CHAR_COMMA, 32'h0000_0000, 1'b0, '{1'b0, 8'd0}},
            '{FUNC_END,   8'h00,      32'h0000_0000, 1'b1, '{1'b0, 8'd3}},
            '{FUNC_END,   8'h00,      32'h0000_0000, 1'b1, '{1'b0, 8'd3}},
            '{FUNC_QUERY, 8'h00,      32'd7,         1'b1, '{1'b1, 8'd3}},
            '{FUNC_BEGIN, 8'h00,      32'h0000_0000, 1'b1, '{1'b0, 8'd0}},
            '{FUNC_QUERY, 8'h00,      32'd0,         1'b1, '{1'b0, 8'd0}},
            '{FUNC_QUERY, 8'h00,      32'hFFFF_FFFF, 1'b1, '{1'b0, 8'd0}}
        };
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_table[r])
            send_req(dir_table[r].func, dir_table[r].ch, dir_table[r].tag,
                     dir_table[r].typed, dir_table[r].res);
        drain();

        iter = 0;
        while (sent_cnt < ITEMS_TARGET) begin
            if (iter == 0) begin
                load_list(KEY_CAPACITY + $urandom_range(0, 6), 1'b1);
                drain();
            end else if (iter == 1) begin
                // receiver holds off while requests keep coming
                long_hold_req = 1'b1;
                run_queries(12);
                run_noise(10);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    load_list(KEY_CAPACITY + $urandom_range(0, 4), 1'b1);
                else if (pick < 65)
                    load_list($urandom_range(0, 8), 1'b0);
                else if (pick < 80)
                    run_queries($urandom_range(2, 10));
                else
                    run_noise($urandom_range(3, 20));
                if ($urandom_range(0, 7) == 0) drain();
            end
            iter++;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests (%0d lookups, %0d granted), %0d uploads filled the table.",
                 sent_cnt, query_cnt, granted_cnt, full_loads);
        $display("Checked %0d results, %0d mismatches.", checked_cnt, mismatches);
        if (mismatches == 0 && grant_q.size() == 0)
            $display("[access_key_table_loader_lookup_core] OK");
        else
            $display("[access_key_table_loader_lookup_core] ERROR");
        $finish;
    end

endmodule
